FILE: rtl/ssp_pkg.sv
// Shared types and constants for the state-space residual predictor.
`default_nettype none
package ssp_pkg;

   localparam int COEF_DEPTH = 80;
   localparam int COEF_AW    = 7;

   localparam logic [1:0] FUNC_WRITE  = 2'd0;
   localparam logic [1:0] FUNC_SAMPLE = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [2:0] SEL_A = 3'd0;
   localparam logic [2:0] SEL_B = 3'd1;
   localparam logic [2:0] SEL_C = 3'd2;
   localparam logic [2:0] SEL_D = 3'd3;
   localparam logic [2:0] SEL_K = 3'd4;

   localparam logic [1:0] CSR_STATE_COUNT  = 2'd0;
   localparam logic [1:0] CSR_INPUT_COUNT  = 2'd1;
   localparam logic [1:0] CSR_OUTPUT_COUNT = 2'd2;
   localparam logic [1:0] CSR_GAIN_ENABLE  = 2'd3;

   typedef struct packed {
      logic [1:0]         func;
      logic [2:0]         matrix_sel;
      logic [1:0]         coef_row;
      logic [1:0]         coef_col;
      logic signed [31:0] coef_value;
      logic signed [31:0] u_0;
      logic signed [31:0] u_1;
      logic signed [31:0] y_0;
      logic signed [31:0] y_1;
   } req_type;

   typedef struct packed {
      logic signed [31:0] residual_0;
      logic signed [31:0] residual_1;
   } rsp_type;

   typedef enum logic [6:0] {
      PH_IDLE = 7'b0000001,
      PH_STRT = 7'b0000010,
      PH_RD   = 7'b0000100,
      PH_MUL  = 7'b0001000,
      PH_ACC  = 7'b0010000,
      PH_FIN  = 7'b0100000,
      PH_DONE = 7'b1000000
   } phase_type;

   typedef enum logic [2:0] {
      LOOP_Y = 3'b001,
      LOOP_K = 3'b010,
      LOOP_X = 3'b100
   } loop_type;

   typedef enum logic [1:0] {
      OPND_X  = 2'd0,
      OPND_U0 = 2'd1,
      OPND_U1 = 2'd2,
      OPND_E  = 2'd3
   } src_type;

   typedef struct packed {
      logic init;
      logic mul;
      logic add;
   } mac_ctl_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic wr_next;
      logic clear;
      logic flip;
   } st_ctl_type;

endpackage
`default_nettype wire

FILE: rtl/ssp_coef.sv
// Coefficient RAM holding A, B, C, D and K with a registered read port.
`default_nettype none
module ssp_coef (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [ssp_pkg::COEF_AW-1:0]   wr_addr,
   input  wire logic signed [31:0]            wr_data,
   input  wire logic [ssp_pkg::COEF_AW-1:0]   rd_addr,
   output logic signed [31:0]                 rd_data
);
   import ssp_pkg::*;

   logic signed [31:0] mem_ff [COEF_DEPTH];
   logic signed [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

FILE: rtl/ssp_state.sv
// State vector RAM with two slots per entry, per-entry bank bits and per-slot valid bits.
`default_nettype none
module ssp_state #(
   parameter int MAX_STATES = 4,
   parameter int SW         = 2
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ssp_pkg::st_ctl_type     ctl,
   input  wire logic [SW-1:0]           rd_idx,
   input  wire logic [SW-1:0]           wr_idx,
   input  wire logic signed [31:0]      wr_data,
   input  wire logic [2:0]              nx,
   output logic signed [31:0]           rd_data
);
   import ssp_pkg::*;

   logic signed [31:0]          mem_ff [2][MAX_STATES];
   logic [1:0][MAX_STATES-1:0]  valid_ff;
   logic [MAX_STATES-1:0]       bank_ff;
   logic signed [31:0]          rd_data_ff;
   logic                        rd_valid_ff;
   logic                        rd_bank;
   logic                        wr_bank;

   assign rd_bank = bank_ff[rd_idx];
   assign wr_bank = bank_ff[wr_idx] ^ ctl.wr_next;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_bank][wr_idx] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_bank][rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         bank_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[rd_bank][rd_idx];
         end
         if (ctl.clear) begin
            valid_ff <= '0;
         end else if (ctl.wr_en) begin
            valid_ff[wr_bank][wr_idx] <= 1'b1;
         end
         if (ctl.flip) begin
            for (int i = 0; i < MAX_STATES; i++) begin
               if (i < 32'(nx)) begin
                  bank_ff[i] <= ~bank_ff[i];
               end
            end
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : 32'sd0;
endmodule
`default_nettype wire

FILE: rtl/ssp_mac.sv
// Q16.16 multiply-accumulate unit with saturating 64-bit accumulator.
`default_nettype none
module ssp_mac (
   input  wire logic                 clock,
   input  wire ssp_pkg::mac_ctl_type ctl,
   input  wire logic signed [31:0]   coef,
   input  wire logic signed [31:0]   opnd,
   input  wire logic signed [63:0]   init_val,
   output logic signed [31:0]        q16
);
   import ssp_pkg::*;

   logic signed [63:0] prod_ff;
   logic signed [63:0] acc_ff;
   logic signed [63:0] acc_in;
   logic [64:0]        sum;
   logic signed [47:0] sh;

   assign sum = {acc_ff[63], acc_ff} + {prod_ff[63], prod_ff};

   always_comb begin
      if (sum[64] != sum[63]) begin
         acc_in = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         acc_in = sum[63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         prod_ff <= coef * opnd;
      end
      if (ctl.init) begin
         acc_ff <= init_val;
      end else if (ctl.add) begin
         acc_ff <= acc_in;
      end
   end

   assign sh = acc_ff[63:16];

   always_comb begin
      if (sh[47:31] == {17{sh[47]}}) begin
         q16 = sh[31:0];
      end else begin
         q16 = sh[47] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/state_space_prediction_residual_core.sv
// Top level: sequencer around the coefficient RAM, state RAM and one MAC.
//
// Usage: req_valid/req_ready carry one command beat (coefficient write,
// sample, or state clear); rsp_valid/rsp_ready carry one residual beat per
// sample. Writes and clears take effect when accepted and give no beat.
// A sample runs its dot products on one MAC; each term of a dot product
// goes through RAM read, multiply and accumulate before the next starts.
// For each output a sample forms the residual and, with gain_enable set,
// corrects every state through K; it then computes the next state vector.
// The next command is taken once the sample has been handed to the
// output register; a residual beat waits there while rsp_ready is low, and
// a finished sample then holds until that register frees.
// Reset (synchronous) zeroes the state vector, empties the output register
// and loads the register defaults; coefficients are undefined until written.
// The user is to write the count and gain registers through the csr_ port
// only while the block is idle; the block itself does not enforce this.
`default_nettype none
module state_space_prediction_residual_core #(
   parameter int MAX_STATES  = 4,
   parameter int MAX_INPUTS  = 2,
   parameter int MAX_OUTPUTS = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ssp_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ssp_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [2:0]       csr_wdata
);
   import ssp_pkg::*;

   localparam int SW     = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
   localparam int NU_LIM = (MAX_INPUTS < 2) ? MAX_INPUTS : 2;
   localparam int NY_LIM = (MAX_OUTPUTS < 2) ? MAX_OUTPUTS : 2;

   phase_type          phase_ff, phase_in;
   loop_type           loop_ff, loop_in;
   logic               p_ff, p_in;
   logic [2:0]         i_ff, i_in;
   logic [3:0]         k_ff, k_in;
   logic signed [31:0] u0_ff, u1_ff, y0_ff, y1_ff;
   logic signed [31:0] e_ff, e_in;
   logic signed [31:0] res0_ff, res0_in, res1_ff, res1_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [2:0]         state_count_ff;
   logic [1:0]         input_count_ff, output_count_ff;
   logic               gain_ff;
   src_type            src_ff, src_in;
   logic               zero_ff;

   logic [2:0]         nx;
   logic [1:0]         nu, ny;
   logic [3:0]         terms;
   logic               k_lt;
   logic [3:0]         kx;
   logic [2:0]         sel;
   logic [3:0]         row, col;
   logic [2:0]         xidx;
   logic               zero_in;
   logic               accept;

   logic               coef_we;
   logic signed [31:0] coef_rd;
   logic signed [31:0] x_rd;
   st_ctl_type         st_ctl;
   mac_ctl_type        mac_ctl;
   logic signed [31:0] mac_coef, mac_opnd, q16;
   logic signed [63:0] init_val;
   logic signed [31:0] y_cur;
   logic [32:0]        diff;
   logic signed [31:0] e_sat;

   assign accept    = req_valid && req_ready;
   assign req_ready = (phase_ff == PH_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      nx = (32'(state_count_ff) > MAX_STATES) ? 3'(MAX_STATES) : state_count_ff;
      nu = (32'(input_count_ff) > NU_LIM) ? 2'(NU_LIM) : input_count_ff;
      ny = (32'(output_count_ff) > NY_LIM) ? 2'(NY_LIM) : output_count_ff;
      terms = (loop_ff == LOOP_K) ? 4'd1 : ({1'b0, nx} + {2'b0, nu});
   end

   // term decode
   always_comb begin
      k_lt = (k_ff < {1'b0, nx});
      kx   = k_ff - {1'b0, nx};
      sel  = SEL_A;
      row  = {1'b0, i_ff};
      col  = k_ff;
      xidx = k_ff[2:0];
      src_in = OPND_X;
      case (loop_ff)
         LOOP_Y: begin
            row = {3'b0, p_ff};
            if (k_lt) begin
               sel = SEL_C;
            end else begin
               sel    = SEL_D;
               col    = kx;
               src_in = kx[0] ? OPND_U1 : OPND_U0;
            end
         end
         LOOP_K: begin
            sel    = SEL_K;
            col    = {3'b0, p_ff};
            xidx   = i_ff;
            src_in = OPND_E;
         end
         LOOP_X: begin
            if (k_lt) begin
               sel = SEL_A;
            end else begin
               sel    = SEL_B;
               col    = kx;
               src_in = kx[0] ? OPND_U1 : OPND_U0;
            end
         end
         default: begin
            sel = SEL_A;
         end
      endcase
      zero_in = (|row[3:2]) || (|col[3:2]);
   end

   assign coef_we = accept && (req_data.func == FUNC_WRITE) && (req_data.matrix_sel <= SEL_K);

   ssp_coef u_coef (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr ({req_data.matrix_sel, req_data.coef_row, req_data.coef_col}),
      .wr_data (req_data.coef_value),
      .rd_addr ({sel, row[1:0], col[1:0]}),
      .rd_data (coef_rd)
   );

   always_comb begin
      st_ctl.rd_en   = (phase_ff == PH_RD);
      st_ctl.wr_en   = (phase_ff == PH_FIN) && (loop_ff != LOOP_Y);
      st_ctl.wr_next = (loop_ff == LOOP_X);
      st_ctl.clear   = accept && (req_data.func == FUNC_CLEAR);
      st_ctl.flip    = (phase_ff == PH_FIN) && (loop_ff == LOOP_X)
                       && ({1'b0, i_ff} + 4'd1 >= {1'b0, nx});
   end

   ssp_state #(
      .MAX_STATES (MAX_STATES),
      .SW         (SW)
   ) u_state (
      .clock   (clock),
      .reset   (reset),
      .ctl     (st_ctl),
      .rd_idx  (SW'(xidx)),
      .wr_idx  (SW'(i_ff)),
      .wr_data (q16),
      .nx      (nx),
      .rd_data (x_rd)
   );

   always_comb begin
      mac_ctl.init = (phase_ff == PH_STRT) || ((phase_ff == PH_MUL) && (loop_ff == LOOP_K));
      mac_ctl.mul  = (phase_ff == PH_MUL);
      mac_ctl.add  = (phase_ff == PH_ACC);
      init_val     = (phase_ff == PH_STRT) ? 64'sd0 : {{16{x_rd[31]}}, x_rd, 16'd0};
      mac_coef     = zero_ff ? 32'sd0 : coef_rd;
      case (src_ff)
         OPND_X:  mac_opnd = x_rd;
         OPND_U0: mac_opnd = u0_ff;
         OPND_U1: mac_opnd = u1_ff;
         OPND_E:  mac_opnd = e_ff;
         default: mac_opnd = x_rd;
      endcase
   end

   ssp_mac u_mac (
      .clock    (clock),
      .ctl      (mac_ctl),
      .coef     (mac_coef),
      .opnd     (mac_opnd),
      .init_val (init_val),
      .q16      (q16)
   );

   always_comb begin
      y_cur = p_ff ? y1_ff : y0_ff;
      diff  = {y_cur[31], y_cur} - {q16[31], q16};
      if (diff[32] != diff[31]) begin
         e_sat = diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         e_sat = diff[31:0];
      end
   end

   // sequencer
   always_comb begin
      phase_in     = phase_ff;
      loop_in      = loop_ff;
      p_in         = p_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      e_in         = e_ff;
      res0_in      = res0_ff;
      res1_in      = res1_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (accept && (req_data.func == FUNC_SAMPLE)) begin
               res0_in = 32'sd0;
               res1_in = 32'sd0;
               p_in    = 1'b0;
               i_in    = 3'd0;
               if (ny != 2'd0) begin
                  loop_in  = LOOP_Y;
                  phase_in = PH_STRT;
               end else if (nx != 3'd0) begin
                  loop_in  = LOOP_X;
                  phase_in = PH_STRT;
               end else begin
                  phase_in = PH_DONE;
               end
            end
         end
         PH_STRT: begin
            k_in     = 4'd0;
            phase_in = (terms == 4'd0) ? PH_FIN : PH_RD;
         end
         PH_RD:  phase_in = PH_MUL;
         PH_MUL: phase_in = PH_ACC;
         PH_ACC: begin
            if (k_ff + 4'd1 < terms) begin
               k_in     = k_ff + 4'd1;
               phase_in = PH_RD;
            end else begin
               phase_in = PH_FIN;
            end
         end
         PH_FIN: begin
            phase_in = PH_STRT;
            if ((loop_ff == LOOP_Y) && gain_ff && (nx != 3'd0)) begin
               e_in    = e_sat;
               loop_in = LOOP_K;
               i_in    = 3'd0;
            end else if ((loop_ff == LOOP_K) && ({1'b0, i_ff} + 4'd1 < {1'b0, nx})) begin
               i_in = i_ff + 3'd1;
            end else if (loop_ff == LOOP_X) begin
               if ({1'b0, i_ff} + 4'd1 < {1'b0, nx}) begin
                  i_in = i_ff + 3'd1;
               end else begin
                  phase_in = PH_DONE;
               end
            end else if ({1'b0, p_ff} + 2'd1 < ny) begin
               loop_in = LOOP_Y;
               p_in    = 1'b1;
            end else if (nx != 3'd0) begin
               loop_in = LOOP_X;
               i_in    = 3'd0;
            end else begin
               phase_in = PH_DONE;
            end
            if (loop_ff == LOOP_Y) begin
               if (p_ff) begin
                  res1_in = e_sat;
               end else begin
                  res0_in = e_sat;
               end
            end
         end
         PH_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.residual_0 = res0_ff;
               rsp_data_in.residual_1 = res1_ff;
               phase_in               = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         loop_ff         <= LOOP_Y;
         rsp_valid_ff    <= 1'b0;
         state_count_ff  <= 3'd4;
         input_count_ff  <= 2'd2;
         output_count_ff <= 2'd2;
         gain_ff         <= 1'b1;
      end else begin
         phase_ff     <= phase_in;
         loop_ff      <= loop_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_STATE_COUNT:  state_count_ff  <= csr_wdata;
               CSR_INPUT_COUNT:  input_count_ff  <= csr_wdata[1:0];
               CSR_OUTPUT_COUNT: output_count_ff <= csr_wdata[1:0];
               CSR_GAIN_ENABLE:  gain_ff         <= csr_wdata[0];
               default:          gain_ff         <= gain_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      e_ff        <= e_in;
      res0_ff     <= res0_in;
      res1_ff     <= res1_in;
      rsp_data_ff <= rsp_data_in;
      if (phase_ff == PH_RD) begin
         src_ff  <= src_in;
         zero_ff <= zero_in;
      end
      if (accept && (req_data.func == FUNC_SAMPLE)) begin
         u0_ff <= req_data.u_0;
         u1_ff <= req_data.u_1;
         y0_ff <= req_data.y_0;
         y1_ff <= req_data.y_1;
      end
   end

`ifndef SYNTHESIS
   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff)) else $error("phase not one-hot");
   a_mul_after_rd: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_MUL) |-> ($past(phase_ff) == PH_RD)) else $error("mul without read");
   a_gain_loop: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FIN && loop_ff == LOOP_K) |-> gain_ff) else $error("correction without gain");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> !req_ready) else $error("ready while busy");
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("result not loaded");
`endif
endmodule
`default_nettype wire

FILE: test/state_space_prediction_residual_core_test.sv
// Testbench for the state-space residual core: directed and random commands checked against a Q16.16 predictor.
`timescale 1ns / 1ps
module state_space_prediction_residual_core_test;
   import ssp_pkg::*;

   localparam longint QMAX = 64'sh7FFFFFFFFFFFFFFF;
   localparam longint QMIN = 64'sh8000000000000000;

   class residual_board;
      int coefs[5][4][4];
      int x[4];
      int unsigned nstates = 4, ninputs = 2, noutputs = 2, gain = 1;
      rsp_type pending[$];
      int errors = 0;

      function void set_reg(logic [1:0] idx, logic [2:0] v);
         case (idx)
            CSR_STATE_COUNT: nstates = v;
            CSR_INPUT_COUNT: ninputs = v[1:0];
            CSR_OUTPUT_COUNT: noutputs = v[1:0];
            CSR_GAIN_ENABLE: gain = v[0];
            default: ;
         endcase
      endfunction

      function longint sadd(longint a, longint b);
         longint s;
         s = a + b;
         if (a[63] == b[63] && s[63] != a[63]) return a[63] ? QMIN : QMAX;
         return s;
      endfunction

      function int sat(longint v);
         if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return int'(v);
      endfunction

      function int to_q16(longint acc);
         return sat(acc >>> 16);
      endfunction

      function void note(req_type r);
         longint u[2], y[2], acc;
         int res[2], xn[4], e;
         int unsigned nx, nu, ny;
         rsp_type o;
         case (r.func)
            FUNC_WRITE: if (r.matrix_sel <= SEL_K)
               coefs[r.matrix_sel][r.coef_row][r.coef_col] = r.coef_value;
            FUNC_CLEAR: foreach (x[i]) x[i] = 0;
            FUNC_SAMPLE: begin
               nx = nstates > 4 ? 4 : nstates;
               nu = ninputs > 2 ? 2 : ninputs;
               ny = noutputs > 2 ? 2 : noutputs;
               u[0] = longint'(r.u_0);
               u[1] = longint'(r.u_1);
               y[0] = longint'(r.y_0);
               y[1] = longint'(r.y_1);
               res[0] = 0;
               res[1] = 0;
               for (int p = 0; p < ny; p++) begin
                  acc = 0;
                  for (int i = 0; i < nx; i++)
                     acc = sadd(acc, longint'(coefs[SEL_C][p][i]) * longint'(x[i]));
                  for (int j = 0; j < nu; j++)
                     acc = sadd(acc, longint'(coefs[SEL_D][p][j]) * u[j]);
                  e = sat(y[p] - longint'(to_q16(acc)));
                  res[p] = e;
                  if (gain[0])
                     for (int j = 0; j < nx; j++)
                        x[j] = to_q16(sadd(longint'(x[j]) * 65536,
                                           longint'(coefs[SEL_K][j][p]) * longint'(e)));
               end
               for (int i = 0; i < nx; i++) begin
                  acc = 0;
                  for (int j = 0; j < nx; j++)
                     acc = sadd(acc, longint'(coefs[SEL_A][i][j]) * longint'(x[j]));
                  for (int j = 0; j < nu; j++)
                     acc = sadd(acc, longint'(coefs[SEL_B][i][j]) * u[j]);
                  xn[i] = to_q16(acc);
               end
               for (int i = 0; i < nx; i++) x[i] = xn[i];
               o.residual_0 = res[0];
               o.residual_1 = res[1];
               pending.push_back(o);
            end
            default: ;
         endcase
      endfunction

      function void report(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endfunction

      function void check(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report("residual beat with nothing expected");
            return;
         end
         want = pending.pop_front();
         if (got.residual_0 !== want.residual_0)
            report($sformatf("residual_0 %h, want %h", got.residual_0, want.residual_0));
         if (got.residual_1 !== want.residual_1)
            report($sformatf("residual_1 %h, want %h", got.residual_1, want.residual_1));
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready, rsp_valid, rsp_ready = 0;
   req_type req_data = '0;
   rsp_type rsp_data;
   logic csr_we = 0;
   logic [1:0] csr_index = '0;
   logic [2:0] csr_wdata = '0;
   residual_board board = new();

   state_space_prediction_residual_core dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      #10ms;
      $display("[state_space_prediction_residual_core] ERROR");
      $finish;
   end

   always @(posedge clock) if (!reset) begin
      if (req_valid && req_ready) board.note(req_data);
      if (rsp_valid && rsp_ready) board.check(rsp_data);
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   int stall = 0;
   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else if (stall > 0) begin
         stall <= stall - 1;
         rsp_ready <= 0;
      end else begin
         stall <= gap_len();
         rsp_ready <= 1;
      end
   end

   function automatic logic [31:0] rand_data();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $signed($urandom_range(0, 524288)) - 262144;
      if (r < 85) return $urandom;
      if (r < 90) return 32'h7FFFFFFF;
      if (r < 95) return 32'h80000000;
      return $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h0;
   endfunction

   function automatic logic [31:0] rand_coef();
      if ($urandom_range(0, 9) < 8) return $signed($urandom_range(0, 65536)) - 32768;
      return rand_data();
   endfunction

   function automatic req_type cmd(logic [1:0] f, logic [2:0] m, logic [1:0] r,
                                   logic [1:0] c, logic [31:0] v);
      req_type it;
      it.func = f;
      it.matrix_sel = m;
      it.coef_row = r;
      it.coef_col = c;
      it.coef_value = v;
      it.u_0 = rand_data();
      it.u_1 = rand_data();
      it.y_0 = rand_data();
      it.y_1 = rand_data();
      return it;
   endfunction

   task automatic send(req_type it);
      req_valid <= 1;
      req_data <= it;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pause(int n);
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_regs(logic [2:0] sc, logic [2:0] ic, logic [2:0] oc, logic [2:0] g);
      logic [2:0] vals[4];
      vals = '{sc, ic, oc, g};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1;
         csr_index <= i[1:0];
         csr_wdata <= vals[i];
         board.set_reg(i[1:0], vals[i]);
         @(posedge clock);
      end
      csr_we <= 0;
      @(posedge clock);
   endtask

   task automatic random_items(int n);
      req_type it;
      int r;
      logic [2:0] m;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         m = ($urandom_range(0, 99) < 90) ? 3'($urandom_range(0, 4))
                                          : 3'($urandom_range(5, 7));
         if (r < 72) it = cmd(FUNC_SAMPLE, 3'($urandom), 2'($urandom), 2'($urandom),
                              $urandom);
         else if (r < 90) it = cmd(FUNC_WRITE, m, 2'($urandom), 2'($urandom), rand_coef());
         else if (r < 96) it = cmd(FUNC_CLEAR, 3'($urandom), 2'($urandom), 2'($urandom),
                                   $urandom);
         else it = cmd(2'd3, 3'($urandom), 2'($urandom), 2'($urandom), $urandom);
         send(it);
         pause(gap_len());
      end
   endtask

   int cfgs[8][4] = '{'{4, 2, 2, 1}, '{1, 0, 1, 0}, '{7, 3, 3, 1}, '{0, 2, 0, 1},
                      '{2, 1, 2, 0}, '{3, 2, 1, 1}, '{4, 0, 2, 0}, '{5, 1, 3, 1}};

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // load every coefficient before any sample reads one
      for (int m = 0; m <= SEL_K; m++)
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
               send(cmd(FUNC_WRITE, 3'(m), 2'(r), 2'(c), rand_coef()));
      send(cmd(FUNC_SAMPLE, 3'd0, 2'd0, 2'd0, 32'd0));
      send(cmd(FUNC_WRITE, SEL_C, 2'd0, 2'd0, 32'h7FFFFFFF));
      send(cmd(FUNC_WRITE, SEL_D, 2'd1, 2'd1, 32'h80000000));
      send(cmd(FUNC_WRITE, 3'd5, 2'd3, 2'd3, 32'h12345678));
      send(cmd(FUNC_WRITE, 3'd7, 2'd0, 2'd0, 32'hFFFFFFFF));
      begin
         req_type it;
         it = cmd(FUNC_SAMPLE, 3'd0, 2'd0, 2'd0, 32'd0);
         it.u_0 = 32'h7FFFFFFF; it.u_1 = 32'h80000000;
         it.y_0 = 32'h80000000; it.y_1 = 32'h7FFFFFFF;
         send(it);
         it.u_0 = 32'h80000000; it.u_1 = 32'h7FFFFFFF;
         it.y_0 = 32'h7FFFFFFF; it.y_1 = 32'h80000000;
         send(it);
         send(it);
      end
      send(cmd(FUNC_CLEAR, 3'd0, 2'd0, 2'd0, 32'd0));
      send(cmd(2'd3, 3'd7, 2'd3, 2'd3, 32'hFFFFFFFF));
      send(cmd(FUNC_SAMPLE, 3'd0, 2'd0, 2'd0, 32'd0));
      send(cmd(FUNC_WRITE, SEL_A, 2'd3, 2'd3, 32'h00010000));
      send(cmd(FUNC_WRITE, SEL_K, 2'd0, 2'd1, 32'hFFFF0000));
      send(cmd(FUNC_SAMPLE, 3'd0, 2'd0, 2'd0, 32'd0));
      drain();
      foreach (cfgs[i]) begin
         set_regs(3'(cfgs[i][0]), 3'(cfgs[i][1]), 3'(cfgs[i][2]), 3'(cfgs[i][3]));
         random_items(60);
         drain();
         random_items(60);
         drain();
      end
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      while (board.pending.size() != 0) begin
         void'(board.pending.pop_front());
         board.report("expected residual never arrived");
      end
      if (board.errors == 0)
         $display("[state_space_prediction_residual_core] OK");
      else
         $display("[state_space_prediction_residual_core] ERROR");
      $finish;
   end
endmodule

FILE: state_space_prediction_residual_core.f
rtl/ssp_pkg.sv
rtl/ssp_coef.sv
rtl/ssp_state.sv
rtl/ssp_mac.sv
rtl/state_space_prediction_residual_core.sv
test/state_space_prediction_residual_core_test.sv
